### hdl/linear_blend_vertex_skinning_assert.svh
// assertion macros shared by the skinning block
`ifndef LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH

`ifndef ASSERT_OFF

// clocked check, skipped while reset is applied
`define LBVS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define LBVS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LBVS_ASSERT(lbl, clk, rst_n, prop, msg)

`define LBVS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hdl/lbvs_pkg.sv
// types, constants and saturation helpers of the skinning block
`timescale 1ns / 1ps

package lbvs_pkg;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_WEIGHT = 1'b1
  } cmd_e;

  localparam int          NUM_COLS       = 4;
  localparam int          NUM_ROWS       = 3;
  localparam logic [3:0]  ELEMS_PER_BONE = 4'd12;
  localparam logic [1:0]  ROW_FIRST      = 2'd0;
  localparam logic [1:0]  ROW_LAST       = 2'd2;
  localparam logic [16:0] WEIGHT_ONE     = 17'h10000;
  localparam int          QUEUE_DEPTH    = 2;

  // one classified beat as it travels from the front to the back
  typedef struct packed {
    logic               is_load;
    logic               in_range;
    logic [8:0]         bone_base;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] mval;
    logic [16:0]        weight;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
    logic signed [31:0] off_z;
    logic               last;
  } item_t;

  // per-row control that follows a matrix row down the datapath
  typedef struct packed {
    logic [1:0] row;
    logic       add_en;
    logic       last;
  } tok_t;

  function automatic logic signed [47:0] sat_to48(input logic signed [67:0] v);
    if (v[67:47] == '0 || v[67:47] == '1) begin
      return v[47:0];
    end else if (v[67]) begin
      return {1'b1, 47'h0};
    end else begin
      return {1'b0, {47{1'b1}}};
    end
  endfunction

  function automatic logic signed [31:0] sat_to32(input logic signed [47:0] v);
    if (v[47:31] == '0 || v[47:31] == '1) begin
      return v[31:0];
    end else if (v[47]) begin
      return {1'b1, 31'h0};
    end else begin
      return {1'b0, {31{1'b1}}};
    end
  endfunction

endpackage

### hdl/linear_blend_vertex_skinning.sv
// top level of the linear blend vertex skinning block
`timescale 1ns / 1ps

// Skins vertices against a store of 3x4 signed Q16.16 bone matrices. A load
// beat (cmd 0) writes one matrix word; a weight beat (cmd 1) adds weight times
// the bone-transformed offset into three 48-bit accumulators, and the weight
// beat marked last sends the saturated 32-bit position and clears them.
// Matrix words read before they are written give undefined results. A front
// stage registers and classifies each beat, a two-entry queue decouples it
// from the back, which owns the bone store. The store is four column banks
// read a whole row per cycle, so the back takes a load beat as a single step and
// a weight beat as three row reads, one row per cycle while no last weight
// beat is held. Each row is read into a register and then flows through four
// register stages (three matrix-by-offset multipliers, row sum and 48-bit
// clamp, weight multiplier, accumulate), and a position is valid once the
// last row of its last weight beat has been accumulated. A last weight beat
// waits in the queue while a previous position is still in flight or not yet
// taken, so the beats of the next vertex may flow on behind a result, but its
// last weight beat starts only once the previous position has been taken.

module linear_blend_vertex_skinning #(
  parameter int MAX_BONES = 128,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input beats
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [6:0]         bone_index_i,
  input  logic [3:0]         matrix_element_i,
  input  logic signed [31:0] matrix_value_i,
  input  logic [16:0]        blend_weight_i,
  input  logic signed [31:0] offset_x_i,
  input  logic signed [31:0] offset_y_i,
  input  logic signed [31:0] offset_z_i,
  input  logic               last_weight_i,
  // skinned positions
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o
);
  import lbvs_pkg::*;

  // front to queue
  logic  push_valid, push_ready;
  item_t push_item;
  // queue to back
  logic  head_valid, pop;
  item_t head_item;

  // accepts beats, checks bone and element range, caps the weight at one
  lbvs_front #(
    .MAX_BONES (MAX_BONES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .bone_index_i     (bone_index_i),
    .matrix_element_i (matrix_element_i),
    .matrix_value_i   (matrix_value_i),
    .blend_weight_i   (blend_weight_i),
    .offset_x_i       (offset_x_i),
    .offset_y_i       (offset_y_i),
    .offset_z_i       (offset_z_i),
    .last_weight_i    (last_weight_i),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_item_o      (push_item)
  );

  // lets the front keep taking beats while the back works through rows
  lbvs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_item_o  (head_item)
  );

  // bone store writes, row reads, arithmetic and the result register
  lbvs_back #(
    .MAX_BONES (MAX_BONES),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o)
  );

endmodule

### hdl/lbvs_front.sv
// input stage: takes beats, range checks, caps the weight, registers the item
`timescale 1ns / 1ps

module lbvs_front #(
  parameter int MAX_BONES = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [6:0]           bone_index_i,
  input  logic [3:0]           matrix_element_i,
  input  logic signed [31:0]   matrix_value_i,
  input  logic [16:0]          blend_weight_i,
  input  logic signed [31:0]   offset_x_i,
  input  logic signed [31:0]   offset_y_i,
  input  logic signed [31:0]   offset_z_i,
  input  logic                 last_weight_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output lbvs_pkg::item_t      push_item_o
);
  import lbvs_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  bone_ok;
  logic  take;

  assign in_ready_o = !valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign bone_ok    = int'(bone_index_i) < MAX_BONES;

  always_comb begin
    item_d.is_load   = (cmd_e'(cmd_i) == CMD_LOAD);
    item_d.in_range  = item_d.is_load ? (bone_ok && matrix_element_i < ELEMS_PER_BONE)
                                      : bone_ok;
    // bone * 3 rows
    item_d.bone_base = 9'({bone_index_i, 1'b0}) + 9'(bone_index_i);
    item_d.row       = matrix_element_i[3:2];
    item_d.col       = matrix_element_i[1:0];
    item_d.mval      = matrix_value_i;
    item_d.weight    = (blend_weight_i[16] && |blend_weight_i[15:0]) ? WEIGHT_ONE
                                                                     : blend_weight_i;
    item_d.off_x     = offset_x_i;
    item_d.off_y     = offset_y_i;
    item_d.off_z     = offset_z_i;
    item_d.last      = last_weight_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

### hdl/lbvs_queue.sv
// two-entry queue between the front and the back
`timescale 1ns / 1ps

module lbvs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  lbvs_pkg::item_t push_item_i,
  output logic            head_valid_o,
  input  logic            pop_i,
  output lbvs_pkg::item_t head_item_o
);
  import lbvs_pkg::*;

  item_t      slot_q [QUEUE_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;
  assign head_item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hdl/lbvs_back.sv
// execution side: bone store, row datapath, accumulators and result register
`timescale 1ns / 1ps

module lbvs_back #(
  parameter int MAX_BONES = 128,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  lbvs_pkg::item_t    head_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o
);
  import lbvs_pkg::*;
  `include "linear_blend_vertex_skinning_assert.svh"

  localparam int Depth  = MAX_BONES * NUM_ROWS;
  localparam int RowAw  = (Depth > 1) ? $clog2(Depth) : 1;

  // issue control
  logic [1:0]       rcnt_q;
  logic             busy_last_q;
  logic             out_valid_q;
  logic             issue;
  logic             issue_row;
  logic             we;
  logic [RowAw-1:0] waddr, raddr;

  // bone store, one bank per matrix column
  logic [31:0] mem_q [NUM_COLS][Depth];
  logic [31:0] rd_q  [NUM_COLS];

  // row datapath
  logic               s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  tok_t               s1_tok_q, s2_tok_q, s3_tok_q, s4_tok_q;
  logic [16:0]        s1_w_q, s2_w_q, s3_w_q;
  logic signed [31:0] s1_off_q [NUM_ROWS];
  logic signed [63:0] s2_p_q   [NUM_ROWS];
  logic signed [31:0] s2_t_q;
  logic signed [47:0] s3_term_q;
  logic signed [65:0] s4_prod_q;
  logic signed [63:0] prod_d   [NUM_ROWS];
  logic signed [47:0] term_d;
  logic signed [65:0] wprod_d;

  // accumulation
  logic signed [47:0] acc_q [NUM_ROWS];
  logic signed [31:0] pos_q [NUM_ROWS];
  logic signed [47:0] add_term, acc_sum, acc_upd;

  always_comb begin
    issue = head_valid_i &&
            (head_item_i.is_load || rcnt_q != ROW_FIRST || !head_item_i.last ||
             (!busy_last_q && !out_valid_q));
    issue_row = issue && !head_item_i.is_load;
    pop_o     = issue && (head_item_i.is_load || rcnt_q == ROW_LAST);
    we        = issue && head_item_i.is_load && head_item_i.in_range;
    waddr     = RowAw'(10'(head_item_i.bone_base) + 10'(head_item_i.row));
    raddr     = RowAw'(10'(head_item_i.bone_base) + 10'(rcnt_q));
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[head_item_i.col][waddr] <= head_item_i.mval;
    end
    for (int b = 0; b < NUM_COLS; b++) begin
      rd_q[b] <= mem_q[b][raddr];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_ROWS; c++) begin
      prod_d[c] = $signed(rd_q[c]) * s1_off_q[c];
    end
    term_d = sat_to48(68'(s2_p_q[0] >>> FRAC_BITS) + 68'(s2_p_q[1] >>> FRAC_BITS) +
                      68'(s2_p_q[2] >>> FRAC_BITS) + 68'(s2_t_q));
    wprod_d = s3_term_q * $signed({1'b0, s3_w_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue_row;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tok_q.row    <= rcnt_q;
    s1_tok_q.add_en <= head_item_i.in_range;
    s1_tok_q.last   <= head_item_i.last;
    s1_w_q          <= head_item_i.weight;
    s1_off_q[0]     <= head_item_i.off_x;
    s1_off_q[1]     <= head_item_i.off_y;
    s1_off_q[2]     <= head_item_i.off_z;
    s2_tok_q        <= s1_tok_q;
    s2_w_q          <= s1_w_q;
    for (int c = 0; c < NUM_ROWS; c++) begin
      s2_p_q[c] <= prod_d[c];
    end
    s2_t_q          <= $signed(rd_q[NUM_COLS-1]);
    s3_tok_q        <= s2_tok_q;
    s3_w_q          <= s2_w_q;
    s3_term_q       <= term_d;
    s4_tok_q        <= s3_tok_q;
    s4_prod_q       <= wprod_d;
  end

  always_comb begin
    add_term = sat_to48(68'(s4_prod_q >>> FRAC_BITS));
    acc_sum  = sat_to48(68'(acc_q[s4_tok_q.row]) + 68'(add_term));
    acc_upd  = s4_tok_q.add_en ? acc_sum : acc_q[s4_tok_q.row];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q      <= ROW_FIRST;
      busy_last_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        acc_q[r] <= '0;
      end
    end else begin
      if (issue_row) begin
        rcnt_q <= (rcnt_q == ROW_LAST) ? ROW_FIRST : rcnt_q + 2'd1;
      end
      if (issue_row && rcnt_q == ROW_FIRST && head_item_i.last) begin
        busy_last_q <= 1'b1;
      end else if (s4_v_q && s4_tok_q.last && s4_tok_q.row == ROW_LAST) begin
        busy_last_q <= 1'b0;
      end
      if (s4_v_q && s4_tok_q.last && s4_tok_q.row == ROW_LAST) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s4_v_q) begin
        acc_q[s4_tok_q.row] <= s4_tok_q.last ? '0 : acc_upd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_v_q && s4_tok_q.last) begin
      pos_q[s4_tok_q.row] <= sat_to32(acc_upd);
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign pos_z_o     = pos_q[2];

  `LBVS_ASSERT(a_rcnt_range, clk_i, rst_ni, rcnt_q <= ROW_LAST, "row counter out of range")
  `LBVS_ASSERT(a_load_on_row_boundary, clk_i, rst_ni, (head_valid_i && head_item_i.is_load) |-> (rcnt_q == ROW_FIRST), "load beat seen in the middle of a weight")
  `LBVS_ASSERT(a_result_from_last, clk_i, rst_ni, $rose(out_valid_q) |-> $past(busy_last_q), "result raised without a last weight in flight")
  `LBVS_ASSERT(a_last_tracked, clk_i, rst_ni, (s4_v_q && s4_tok_q.last) |-> busy_last_q, "last weight row retired while untracked")

endmodule

### bench/linear_blend_vertex_skinning_tb.sv
// self-checking bench for the skinning block: directed rows, random vertex streams, scoreboard
`timescale 1ns / 1ps

module linear_blend_vertex_skinning_tb;
  import lbvs_pkg::*;

  localparam int MAX_BONES     = 128;
  localparam int FRAC_BITS     = 16;
  localparam int BONE_WORDS    = int'(ELEMS_PER_BONE);
  localparam int RAND_ITEMS    = 1800;
  localparam int PRELOAD_BONES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;

  localparam logic signed [79:0] ACC_HI = 80'sh7FFF_FFFF_FFFF;
  localparam logic signed [79:0] ACC_LO = -80'sh8000_0000_0000;
  localparam logic signed [47:0] POS_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] POS_LO = -48'sh0000_8000_0000;

  // one input beat plus an optional hand-typed position
  typedef struct {
    cmd_e               cmd;
    logic [6:0]         bone;
    logic [3:0]         elem;
    logic signed [31:0] mval;
    logic [16:0]        weight;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
    logic signed [31:0] off_z;
    logic               last;
    bit                 has_exp;
    logic signed [31:0] exp_x;
    logic signed [31:0] exp_y;
    logic signed [31:0] exp_z;
  } skin_beat_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } skin_pos_t;

  // dut inputs, all known from time zero
  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_ready_o;
  logic               cmd_i            = 1'b0;
  logic [6:0]         bone_index_i     = '0;
  logic [3:0]         matrix_element_i = '0;
  logic signed [31:0] matrix_value_i   = '0;
  logic [16:0]        blend_weight_i   = '0;
  logic signed [31:0] offset_x_i       = '0;
  logic signed [31:0] offset_y_i       = '0;
  logic signed [31:0] offset_z_i       = '0;
  logic               last_weight_i    = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i      = 1'b0;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic signed [31:0] pos_z_o;

  // hand-typed position that rides along with the beat on the input
  bit                 beat_has_exp = 1'b0;
  logic signed [31:0] beat_exp_x   = '0;
  logic signed [31:0] beat_exp_y   = '0;
  logic signed [31:0] beat_exp_z   = '0;

  // predictor state: bone matrices and the three position sums
  logic signed [31:0] bone_words [MAX_BONES * BONE_WORDS];
  logic signed [47:0] acc_pos [3];
  skin_pos_t          pending_pos [$];

  // stimulus side bookkeeping: which words were ever written, which bones are usable
  bit                 word_loaded [MAX_BONES * BONE_WORDS];
  bit                 bone_ready [MAX_BONES];
  int                 ready_list [$];

  int                 mismatch_count = 0;
  int                 cycle_count    = 0;
  int                 beats_sent     = 0;
  int                 tx_quiet_left  = 0;
  bit                 vertex_phase   = 1'b0;
  bit                 hold_done      = 1'b0;

  linear_blend_vertex_skinning #(
    .MAX_BONES (MAX_BONES),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .bone_index_i     (bone_index_i),
    .matrix_element_i (matrix_element_i),
    .matrix_value_i   (matrix_value_i),
    .blend_weight_i   (blend_weight_i),
    .offset_x_i       (offset_x_i),
    .offset_y_i       (offset_y_i),
    .offset_z_i       (offset_z_i),
    .last_weight_i    (last_weight_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .pos_z_o          (pos_z_o)
  );

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic signed [47:0] clamp48(input logic signed [79:0] v);
    if (v > ACC_HI) begin
      return ACC_HI[47:0];
    end else if (v < ACC_LO) begin
      return ACC_LO[47:0];
    end
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [47:0] v);
    if (v > POS_HI) begin
      return POS_HI[31:0];
    end else if (v < POS_LO) begin
      return POS_LO[31:0];
    end
    return v[31:0];
  endfunction

  // updates the bone store or the sums for one accepted beat, and says
  // whether the beat closes a vertex
  task automatic skin_predict(input cmd_e cmd, input logic [6:0] bone, input logic [3:0] elem,
                              input logic signed [31:0] mval, input logic [16:0] weight,
                              input logic signed [31:0] ox, input logic signed [31:0] oy,
                              input logic signed [31:0] oz, input logic last,
                              output bit emits, output skin_pos_t pos);
    logic signed [79:0] offs [3];
    logic signed [79:0] term;
    logic signed [79:0] mword;
    logic signed [79:0] wgt;
    int                 base;
    emits = 1'b0;
    pos.x = '0;
    pos.y = '0;
    pos.z = '0;
    base  = int'(bone) * BONE_WORDS;
    if (cmd == CMD_LOAD) begin
      // element 12..15 drops the word; every 7-bit bone is in range at 128 bones
      if (int'(bone) < MAX_BONES && elem < ELEMS_PER_BONE) begin
        bone_words[base + int'(elem)] = mval;
      end
      return;
    end
    offs[0] = ox;
    offs[1] = oy;
    offs[2] = oz;
    // weights above one count as one
    wgt = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    if (int'(bone) < MAX_BONES) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        // translation word plus the three floored rotation products
        term = bone_words[base + r * NUM_COLS + 3];
        for (int c = 0; c < 3; c++) begin
          mword = bone_words[base + r * NUM_COLS + c];
          term  = term + ((mword * offs[c]) >>> FRAC_BITS);
        end
        term       = clamp48(term);
        term       = clamp48((term * wgt) >>> FRAC_BITS);
        acc_pos[r] = clamp48(acc_pos[r] + term);
      end
    end
    if (last) begin
      pos.x = clamp32(acc_pos[0]);
      pos.y = clamp32(acc_pos[1]);
      pos.z = clamp32(acc_pos[2]);
      for (int r = 0; r < NUM_ROWS; r++) acc_pos[r] = '0;
      emits = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // scoreboard: absorb accepted input beats, compare accepted positions
  // ---------------------------------------------------------------------------

  initial begin : store_clear
    foreach (bone_words[i]) bone_words[i] = '0;
    foreach (acc_pos[i]) acc_pos[i] = '0;
  end

  always @(posedge clk_i) begin : scoreboard
    bit        emits;
    skin_pos_t pos;
    skin_pos_t want;
    cycle_count++;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        skin_predict(cmd_e'(cmd_i), bone_index_i, matrix_element_i, matrix_value_i,
                     blend_weight_i, offset_x_i, offset_y_i, offset_z_i, last_weight_i,
                     emits, pos);
        if (emits) begin
          // a typed-in row overrides the predicted position
          if (beat_has_exp) begin
            pos.x = beat_exp_x;
            pos.y = beat_exp_y;
            pos.z = beat_exp_z;
          end
          pending_pos.push_back(pos);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_pos.size() == 0) begin
          $error("position beat (%0d, %0d, %0d) with nothing pending",
                 pos_x_o, pos_y_o, pos_z_o);
          mismatch_count++;
        end else begin
          want = pending_pos.pop_front();
          check_field("pos_x", want.x, pos_x_o);
          check_field("pos_y", want.y, pos_y_o);
          check_field("pos_z", want.z, pos_z_o);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // random value pickers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int gap_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // q16.16 value: small share within +-4.0, an edge share of corner values, rest any bits
  function automatic logic signed [31:0] q16_pick(input int small_pct, input int edge_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < small_pct) return $signed($urandom_range(0, 524288)) - 32'sd262144;
    if (r < small_pct + edge_pct) begin
      case ($urandom_range(0, 5))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sh0000_0000;
        3:       return 32'sh0001_0000;
        4:       return -32'sh0001_0000;
        default: return -32'sh1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [16:0] weight_pick(input bit harsh);
    int r;
    r = $urandom_range(0, 99);
    if (harsh) begin
      case ($urandom_range(0, 3))
        0:       return 17'd0;
        1:       return 17'd1;
        2:       return WEIGHT_ONE;
        default: return 17'h1FFFF;
      endcase
    end
    if (r < 8) return ($urandom_range(0, 1) != 0) ? WEIGHT_ONE : 17'd0;
    if (r < 18) return 17'($urandom_range(65537, 131071));
    return 17'($urandom_range(0, 65536));
  endfunction

  function automatic int any_ready_bone();
    return ready_list[$urandom_range(0, ready_list.size() - 1)];
  endfunction

  // fields a beat ignores are filled with noise
  function automatic skin_beat_t load_row(input logic [6:0] bone, input logic [3:0] elem,
                                          input logic signed [31:0] value, input logic last);
    skin_beat_t b;
    b.cmd     = CMD_LOAD;
    b.bone    = bone;
    b.elem    = elem;
    b.mval    = value;
    b.weight  = 17'($urandom_range(0, 131071));
    b.off_x   = $urandom;
    b.off_y   = $urandom;
    b.off_z   = $urandom;
    b.last    = last;
    b.has_exp = 1'b0;
    b.exp_x   = '0;
    b.exp_y   = '0;
    b.exp_z   = '0;
    return b;
  endfunction

  function automatic skin_beat_t weight_row(input int bone, input logic [16:0] w,
                                            input logic signed [31:0] x,
                                            input logic signed [31:0] y,
                                            input logic signed [31:0] z, input logic last);
    skin_beat_t b;
    b.cmd     = CMD_WEIGHT;
    b.bone    = 7'(bone);
    b.elem    = 4'($urandom_range(0, 15));
    b.mval    = $urandom;
    b.weight  = w;
    b.off_x   = x;
    b.off_y   = y;
    b.off_z   = z;
    b.last    = last;
    b.has_exp = 1'b0;
    b.exp_x   = '0;
    b.exp_y   = '0;
    b.exp_z   = '0;
    return b;
  endfunction

  function automatic skin_beat_t with_result(input skin_beat_t b, input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input logic signed [31:0] z);
    skin_beat_t o;
    o         = b;
    o.has_exp = 1'b1;
    o.exp_x   = x;
    o.exp_y   = y;
    o.exp_z   = z;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------

  // drive one beat at the falling edge, hold it until taken, then maybe idle
  task automatic push_beat(input skin_beat_t b);
    int  idx;
    int  gap;
    bit  full;
    if (b.cmd == CMD_LOAD && b.elem < ELEMS_PER_BONE) begin
      idx = int'(b.bone) * BONE_WORDS + int'(b.elem);
      word_loaded[idx] = 1'b1;
      if (!bone_ready[b.bone]) begin
        full = 1'b1;
        for (int k = 0; k < BONE_WORDS; k++) begin
          if (!word_loaded[int'(b.bone) * BONE_WORDS + k]) full = 1'b0;
        end
        if (full) begin
          bone_ready[b.bone] = 1'b1;
          ready_list.push_back(int'(b.bone));
        end
      end
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    cmd_i            <= b.cmd;
    bone_index_i     <= b.bone;
    matrix_element_i <= b.elem;
    matrix_value_i   <= b.mval;
    blend_weight_i   <= b.weight;
    offset_x_i       <= b.off_x;
    offset_y_i       <= b.off_y;
    offset_z_i       <= b.off_z;
    last_weight_i    <= b.last;
    beat_has_exp     <= b.has_exp;
    beat_exp_x       <= b.exp_x;
    beat_exp_y       <= b.exp_y;
    beat_exp_z       <= b.exp_z;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    // occasional quiet stretches with back-to-back beats
    if (tx_quiet_left > 0) begin
      tx_quiet_left--;
      gap = 0;
    end else begin
      gap = gap_pick();
      if ($urandom_range(0, 99) == 0) tx_quiet_left = $urandom_range(30, 100);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      for (int k = 1; k < gap; k++) @(negedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result sink: random ready, one long hold-off once vertex traffic starts
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int len;
    wait (rst_ni);
    forever begin
      if (vertex_phase && !hold_done) begin
        // hold off long enough for the queue and pipeline to back up into the input
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(negedge clk_i);
        hold_done = 1'b1;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      for (int k = 1; k < len; k++) @(negedge clk_i);
      len = gap_pick();
      if (len > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        for (int k = 1; k < len; k++) @(negedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    skin_beat_t directed_rows [$];
    skin_beat_t b;
    int         rand_goal;
    int         pick;
    int         nw;
    int         bsel;
    bit         harsh;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // bone 0 as identity with zero translation, so positions equal offsets
    for (int e = 0; e < BONE_WORDS; e++) begin
      directed_rows.push_back(load_row(7'd0, 4'(e),
                                       (e % NUM_COLS == e / NUM_COLS) ? 32'sh0001_0000 : 32'sh0,
                                       1'b0));
    end
    // empty vertex: a single zero-weight last beat
    directed_rows.push_back(with_result(weight_row(0, 17'd0, 32'sh0, 32'sh0, 32'sh0, 1'b1),
                                        32'sh0, 32'sh0, 32'sh0));
    directed_rows.push_back(with_result(weight_row(0, WEIGHT_ONE, 32'sh0001_0000,
                                                   -32'sh0001_0000, 32'sh0002_0000, 1'b1),
                                        32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000));
    // extreme offsets pass through the identity unchanged
    directed_rows.push_back(with_result(weight_row(0, WEIGHT_ONE, 32'sh7FFF_FFFF,
                                                   32'sh8000_0000, 32'sh0, 1'b1),
                                        32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0));
    // weight above one counts as one
    directed_rows.push_back(with_result(weight_row(0, 17'h1FFFF, 32'sh0003_0000,
                                                   -32'sh0002_8000, 32'sh0000_8000, 1'b1),
                                        32'sh0003_0000, -32'sh0002_8000, 32'sh0000_8000));
    // elements past the matrix are dropped, last is ignored on loads
    directed_rows.push_back(load_row(7'd0, 4'd12, -32'sh1, 1'b1));
    directed_rows.push_back(load_row(7'd0, 4'd15, 32'sh8000_0000, 1'b0));
    // huge row 0 so the x sum clamps at 48 bits, then pulls back down
    directed_rows.push_back(load_row(7'd0, 4'd0, 32'sh7FFF_FFFF, 1'b0));
    directed_rows.push_back(load_row(7'd0, 4'd3, 32'sh7FFF_FFFF, 1'b0));
    directed_rows.push_back(weight_row(0, WEIGHT_ONE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                       32'sh7FFF_FFFF, 1'b0));
    directed_rows.push_back(weight_row(0, WEIGHT_ONE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                       32'sh7FFF_FFFF, 1'b0));
    directed_rows.push_back(weight_row(0, WEIGHT_ONE, 32'sh8000_0000, 32'sh0, 32'sh0, 1'b1));
    // half weight on negative offsets checks the floor rounding
    directed_rows.push_back(weight_row(0, 17'h08000, 32'sh8000_0000, 32'sh8000_0000,
                                       32'sh8000_0000, 1'b1));
    directed_rows.push_back(weight_row(0, 17'd1, -32'sh1, -32'sh1, -32'sh1, 1'b1));

    foreach (directed_rows[i]) push_beat(directed_rows[i]);

    rand_goal = beats_sent + RAND_ITEMS;

    // fill a handful of bones, the top index among them, before any vertex uses them
    for (int n = 0; n < PRELOAD_BONES; n++) begin
      bsel = (n == 0) ? MAX_BONES - 1 : $urandom_range(1, MAX_BONES - 2);
      for (int e = 0; e < BONE_WORDS; e++) begin
        push_beat(load_row(7'(bsel), 4'(e), q16_pick(70, 10), 1'($urandom_range(0, 1))));
      end
    end
    vertex_phase = 1'b1;

    while (beats_sent < rand_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 72 || pick >= 90) begin
        // one vertex; the harsh flavor uses corner weights and offsets
        harsh = (pick >= 90);
        nw    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        if (nw == 0) begin
          push_beat(weight_row(any_ready_bone(), 17'd0, q16_pick(60, 10), q16_pick(60, 10),
                               q16_pick(60, 10), 1'b1));
        end else begin
          for (int k = 0; k < nw; k++) begin
            // a stray matrix write inside the vertex
            if ($urandom_range(0, 19) == 0) begin
              push_beat(load_row(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                                 q16_pick(60, 15), 1'($urandom_range(0, 1))));
            end
            if (harsh) begin
              b = weight_row(any_ready_bone(), weight_pick(1'b1), q16_pick(0, 70),
                             q16_pick(0, 70), q16_pick(0, 70), k == nw - 1);
            end else begin
              b = weight_row(any_ready_bone(), weight_pick(1'b0), q16_pick(60, 10),
                             q16_pick(60, 10), q16_pick(60, 10), k == nw - 1);
            end
            push_beat(b);
          end
        end
      end else if (pick < 86) begin
        // single word write, element past the matrix now and then
        push_beat(load_row(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                           q16_pick(60, 15), 1'($urandom_range(0, 1))));
      end else begin
        // whole bone rewrite
        bsel = $urandom_range(0, MAX_BONES - 1);
        for (int e = 0; e < BONE_WORDS; e++) begin
          push_beat(load_row(7'(bsel), 4'(e), q16_pick(70, 10), 1'($urandom_range(0, 1))));
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_pos.size() != 0) @(posedge clk_i);
    // let a late extra position show up if there is one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_pos.size() != 0) begin
      $error("%0d positions never arrived", pending_pos.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
